/* sv/sorted_kerning_pair_table_unit_macros.svh */
// Assertion macros for the sorted kerning pair table unit.
`ifndef SORTED_KERNING_PAIR_TABLE_UNIT_MACROS_SVH
`define SORTED_KERNING_PAIR_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SKPT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("skpt: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define SKPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("skpt: next-cycle check failed");

`endif

/* sv/skpt_pkg.sv */
// Types and constants shared by the sorted kerning pair table unit.
`default_nettype none

package skpt_pkg;

    localparam int CHAR_W = 21;
    localparam int DIST_W = 16;
    localparam int KEY_W  = 2 * CHAR_W;

    typedef logic [CHAR_W-1:0] char_t;
    typedef logic [KEY_W-1:0]  key_t;
    typedef logic signed [DIST_W-1:0] dist_t;

    typedef struct packed {
        char_t left_char;
        char_t right_char;
        dist_t dist_val;
    } entry_t;

    localparam logic KIND_LOOKUP = 1'b0;
    localparam logic KIND_SET    = 1'b1;

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_SRCH    = 8'b0000_0010,
        S_CMP     = 8'b0000_0100,
        S_DECIDE  = 8'b0000_1000,
        S_MOVE_RD = 8'b0001_0000,
        S_MOVE_WR = 8'b0010_0000,
        S_WRITE   = 8'b0100_0000,
        S_OUT     = 8'b1000_0000
    } state_t;

endpackage

`default_nettype wire

/* sv/skpt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module skpt_ram #(
    parameter int WIDTH = 58,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* sv/sorted_kerning_pair_table_unit.sv */
// Sorted kerning pair table: binary search, update, insert and delete over one RAM.
//
//   channel | signals                                  | direction
//   --------+------------------------------------------+----------
//   in      | in_valid in_ready kind left_char         | into block
//           | right_char offset                        |
//   out     | out_valid out_ready distance found       | out of block
//           | full_res                                 |
//
// A lookup is a binary search over the n stored pairs: each step issues a read in S_SRCH
// and compares the registered read data of the entry RAM in S_CMP.
// Delete shifts later entries down; insert shifts entries up, then writes; update writes in place.
// One word is in work at a time; in_ready is high only while the sequencer is idle.
// A stalled result holds in the output register; the next word is taken meanwhile.
// Reset empties the table at once (entry count to zero); no clearing pass.
`default_nettype none

`include "sorted_kerning_pair_table_unit_macros.svh"

module sorted_kerning_pair_table_unit #(
    parameter int CAPACITY = 256
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic          kind,
    input  wire skpt_pkg::char_t left_char,
    input  wire skpt_pkg::char_t right_char,
    input  wire skpt_pkg::dist_t offset,
    output logic               out_valid,
    input  wire logic          out_ready,
    output skpt_pkg::dist_t    distance,
    output logic               found,
    output logic               full_res
);

    import skpt_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            out_valid_reg, out_valid_next;

    logic            kind_reg, kind_next;
    key_t            key_reg, key_next;
    dist_t           off_reg, off_next;
    logic [CW-1:0]   lo_reg, lo_next;
    logic [CW-1:0]   hi_reg, hi_next;
    logic [CW-1:0]   mid_reg, mid_next;
    logic [CW-1:0]   cur_reg, cur_next;
    logic            hit_reg, hit_next;
    dist_t           old_reg, old_next;
    logic            full_reg, full_next;
    logic            del_reg, del_next;
    dist_t           dist_out_reg, dist_out_next;
    logic            found_out_reg, found_out_next;
    logic            full_out_reg, full_out_next;

    logic            ram_wr_en;
    logic [AW-1:0]   ram_wr_addr;
    entry_t          ram_wr_data;
    logic            ram_rd_en;
    logic [AW-1:0]   ram_rd_addr;
    entry_t          ram_rd_data;

    logic [CW:0]     mid_sum;
    logic [CW-1:0]   mid_val;
    key_t            rd_key;
    logic [CW-1:0]   cur_inc;
    logic [CW-1:0]   cur_dec;

    skpt_ram #(
        .WIDTH($bits(entry_t)),
        .DEPTH(CAPACITY)
    ) u_ram (
        .clk    (clk),
        .wr_en  (ram_wr_en),
        .wr_addr(ram_wr_addr),
        .wr_data(ram_wr_data),
        .rd_en  (ram_rd_en),
        .rd_addr(ram_rd_addr),
        .rd_data(ram_rd_data)
    );

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_val = mid_sum[CW:1];
    assign rd_key  = {ram_rd_data.left_char, ram_rd_data.right_char};
    assign cur_inc = cur_reg + ONE_C;
    assign cur_dec = cur_reg - ONE_C;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign distance  = dist_out_reg;
    assign found     = found_out_reg;
    assign full_res  = full_out_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        key_next       = key_reg;
        off_next       = off_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        cur_next       = cur_reg;
        hit_next       = hit_reg;
        old_next       = old_reg;
        full_next      = full_reg;
        del_next       = del_reg;
        dist_out_next  = dist_out_reg;
        found_out_next = found_out_reg;
        full_out_next  = full_out_reg;

        ram_wr_en   = 1'b0;
        ram_wr_addr = cur_reg[AW-1:0];
        ram_wr_data = ram_rd_data;
        ram_rd_en   = 1'b0;
        ram_rd_addr = mid_val[AW-1:0];

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next  = kind;
                    key_next   = {left_char, right_char};
                    off_next   = offset;
                    lo_next    = '0;
                    hi_next    = count_reg;
                    hit_next   = 1'b0;
                    old_next   = '0;
                    full_next  = 1'b0;
                    state_next = S_SRCH;
                end
            end
            S_SRCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    ram_rd_en  = 1'b1;
                    mid_next   = mid_val;
                    state_next = S_CMP;
                end
                else
                begin
                    state_next = S_DECIDE;
                end
            end
            S_CMP:
            begin
                if (rd_key < key_reg)
                begin
                    lo_next = mid_reg + ONE_C;
                end
                else
                begin
                    hi_next  = mid_reg;
                    hit_next = (rd_key == key_reg);
                    old_next = ram_rd_data.dist_val;
                end
                state_next = S_SRCH;
            end
            S_DECIDE:
            begin
                if (kind_reg == KIND_LOOKUP)
                begin
                    state_next = S_OUT;
                end
                else if (hit_reg)
                begin
                    if (off_reg != '0)
                    begin
                        state_next = S_WRITE;
                    end
                    else
                    begin
                        del_next   = 1'b1;
                        cur_next   = lo_reg;
                        state_next = S_MOVE_RD;
                    end
                end
                else if (off_reg == '0)
                begin
                    state_next = S_OUT;
                end
                else if (count_reg >= CAP_C)
                begin
                    full_next  = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    del_next   = 1'b0;
                    cur_next   = count_reg;
                    state_next = S_MOVE_RD;
                end
            end
            S_MOVE_RD:
            begin
                if (del_reg)
                begin
                    if (cur_inc < count_reg)
                    begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = cur_inc[AW-1:0];
                        state_next  = S_MOVE_WR;
                    end
                    else
                    begin
                        count_next = count_reg - ONE_C;
                        state_next = S_OUT;
                    end
                end
                else
                begin
                    if (cur_reg > lo_reg)
                    begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = cur_dec[AW-1:0];
                        state_next  = S_MOVE_WR;
                    end
                    else
                    begin
                        state_next = S_WRITE;
                    end
                end
            end
            S_MOVE_WR:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = cur_reg[AW-1:0];
                ram_wr_data = ram_rd_data;
                cur_next    = del_reg ? cur_inc : cur_dec;
                state_next  = S_MOVE_RD;
            end
            S_WRITE:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = lo_reg[AW-1:0];
                ram_wr_data = '{left_char:  key_reg[KEY_W-1:CHAR_W],
                                right_char: key_reg[CHAR_W-1:0],
                                dist_val:   off_reg};
                if (!hit_reg)
                begin
                    count_next = count_reg + ONE_C;
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    dist_out_next  = hit_reg ? old_reg : '0;
                    found_out_next = hit_reg;
                    full_out_next  = full_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        key_reg       <= key_next;
        off_reg       <= off_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mid_reg       <= mid_next;
        cur_reg       <= cur_next;
        hit_reg       <= hit_next;
        old_reg       <= old_next;
        full_reg      <= full_next;
        del_reg       <= del_next;
        dist_out_reg  <= dist_out_next;
        found_out_reg <= found_out_next;
        full_out_reg  <= full_out_next;
    end

    `SKPT_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CAP_C)
    `SKPT_ASSERT_NOW(a_full_no_hit, clk, rst_n, out_valid && full_res,
                     !found && distance == '0)
    `SKPT_ASSERT_NEXT(a_insert_grows, clk, rst_n, state_reg == S_WRITE && !hit_reg,
                      count_reg == $past(count_reg) + ONE_C)

endmodule

`default_nettype wire
